// ===== rtl/core/vcc_pkg.sv =====
// ----------------------------------------------------------------------------
// vcc_pkg
// Shared types and constants of the vending coin controller: field widths,
// action, coin, command, status and register codes.
// ----------------------------------------------------------------------------
`default_nettype none

package vcc_pkg;

  localparam int ACTION_W    = 3;
  localparam int PRODUCT_W   = 2;
  localparam int COIN_W      = 2;
  localparam int QTY_W       = 8;
  localparam int STATUS_W    = 4;
  localparam int MONEY_W     = 10;
  localparam int STOCK_W     = 8;
  localparam int PRICE_W     = 8;
  localparam int TICKS_W     = 16;
  localparam int COIN_ADD_W  = 5;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 40;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [MONEY_W-1:0]    DEPOSIT_MAX   = 10'd1023;
  localparam logic [TICKS_W-1:0]    TICKS_MAX     = 16'hFFFF;
  localparam logic [TICKS_W-1:0]    TIMEOUT_RESET = 16'd30;
  localparam logic [COIN_ADD_W-1:0] VAL_NICKEL    = 5'd5;
  localparam logic [COIN_ADD_W-1:0] VAL_DIME      = 5'd10;
  localparam logic [COIN_ADD_W-1:0] VAL_QUARTER   = 5'd25;

  typedef enum logic [ACTION_W-1:0] {
    ACT_TICK    = 3'd0,
    ACT_SELECT  = 3'd1,
    ACT_COIN    = 3'd2,
    ACT_CONFIRM = 3'd3,
    ACT_RESTOCK = 3'd4
  } action_e;

  typedef enum logic [COIN_W-1:0] {
    COIN_NICKEL  = 2'd0,
    COIN_DIME    = 2'd1,
    COIN_QUARTER = 2'd2
  } coin_e;

  typedef enum logic [2:0] {
    OP_NONE    = 3'd0,
    OP_TICK    = 3'd1,
    OP_SELECT  = 3'd2,
    OP_COIN    = 3'd3,
    OP_CONFIRM = 3'd4,
    OP_RESTOCK = 3'd5
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_NONE          = 4'd0,
    ST_OPENED        = 4'd1,
    ST_OUT_OF_STOCK  = 4'd2,
    ST_COIN_TAKEN    = 4'd3,
    ST_VENDED        = 4'd4,
    ST_REFUNDED      = 4'd5,
    ST_TIMEOUT       = 4'd6,
    ST_RESTOCKED     = 4'd7,
    ST_RESTOCK_ERROR = 4'd8
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PRICE_FIRST  = 2'd0,
    CFG_PRICE_SECOND = 2'd1,
    CFG_PRICE_THIRD  = 2'd2,
    CFG_TIMEOUT      = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    op_e                   op;
    logic [PRODUCT_W-1:0]  product;
    logic [COIN_ADD_W-1:0] coin_add;
    logic [QTY_W-1:0]      qty;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    logic                  we;
    cfg_idx_e              idx;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

endpackage

`default_nettype wire

// ===== rtl/core/vending_coin_controller.sv =====
// ----------------------------------------------------------------------------
// vending_coin_controller
// Three-product vending controller: stock, coin session, vend and refund.
// ----------------------------------------------------------------------------
// One word is accepted per cycle while the command queue has room; each word
// gives exactly one result word, in order. An accepted word is held in the
// two-entry command queue behind the decoder, then in the result register of
// the execution stage until the master side takes it. The execution stage
// updates all session and stock state as it takes a command, so the sustained
// rate is one word per cycle whenever the master side takes results. Prices and
// the timeout are to be written by the user through the cfg port only while no
// word is in flight; the block itself does not enforce this.
`default_nettype none

module vending_coin_controller #(
  parameter int NUM_PRODUCTS = 3
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // cfg: 0 price_first, 1 price_second, 2 price_third, 3 timeout_ticks
  input  wire logic                              cfg_we_i,
  input  wire logic [vcc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [vcc_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // action[2:0], product[4:3], coin_kind[6:5], quantity[14:7], zero[15]
  input  wire logic [vcc_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // status[3:0], change_due[13:4], deposit_now[23:14], stock_now[31:24],
  // session_open[32], zero[39:33]
  output logic [vcc_pkg::OUT_TDATA_W-1:0]        m_axis_tdata
);

  vcc_pkg::cmd_t      push_cmd, head_cmd;
  vcc_pkg::q_status_t q_status;
  vcc_pkg::cfg_wr_t   cfg_wr;
  logic               q_push, q_pop, q_valid, q_ready;

  assign cfg_wr = '{we: cfg_we_i, idx: vcc_pkg::cfg_idx_e'(cfg_idx_i), data: cfg_wdata_i};

  vcc_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .q_ready_i     (q_ready),
    .q_push_o      (q_push),
    .q_cmd_o       (push_cmd)
  );

  vcc_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (q_push),
    .cmd_i    (push_cmd),
    .pop_i    (q_pop),
    .head_o   (head_cmd),
    .valid_o  (q_valid),
    .ready_o  (q_ready),
    .status_o (q_status)
  );

  vcc_back #(
    .NUM_PRODUCTS (NUM_PRODUCTS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_wr),
    .q_valid_i     (q_valid),
    .q_cmd_i       (head_cmd),
    .q_pop_o       (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

`ifndef ASSERT_OFF
  // queue cannot be full and empty at once
  a_queue_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_status.full && q_status.empty))
    else $error("command queue reports full and empty");

  // a session that just opened or took a coin stays open
  a_open_session: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[3:0] == vcc_pkg::ST_OPENED ||
                      m_axis_tdata[3:0] == vcc_pkg::ST_COIN_TAKEN)
    |-> m_axis_tdata[32])
    else $error("session closed after open or coin");

  // closing a session empties the deposit
  a_close_session: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[3:0] == vcc_pkg::ST_VENDED ||
                      m_axis_tdata[3:0] == vcc_pkg::ST_REFUNDED ||
                      m_axis_tdata[3:0] == vcc_pkg::ST_TIMEOUT)
    |-> !m_axis_tdata[32] && m_axis_tdata[23:14] == '0)
    else $error("deposit or session left after close");

  // a taken coin leaves at least a nickel on deposit
  a_coin_deposit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[3:0] == vcc_pkg::ST_COIN_TAKEN
    |-> m_axis_tdata[23:14] >= 10'(vcc_pkg::VAL_NICKEL))
    else $error("coin taken with deposit below a nickel");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/vcc_front.sv =====
// ----------------------------------------------------------------------------
// vcc_front
// Input side: takes words from the slave stream and turns each into a
// command for the back end, resolving the action and the coin value.
// ----------------------------------------------------------------------------
`default_nettype none

module vcc_front (
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  wire logic [vcc_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  input  wire logic                             q_ready_i,
  output logic                                  q_push_o,
  output vcc_pkg::cmd_t                         q_cmd_o
);

  logic [vcc_pkg::ACTION_W-1:0] action;
  logic [vcc_pkg::COIN_W-1:0]   coin;

  assign action = s_axis_tdata[2:0];
  assign coin   = s_axis_tdata[6:5];

  assign s_axis_tready = q_ready_i;
  assign q_push_o      = s_axis_tvalid && q_ready_i;

  always_comb begin
    q_cmd_o          = '0;
    q_cmd_o.op       = vcc_pkg::OP_NONE;
    q_cmd_o.product  = s_axis_tdata[4:3];
    q_cmd_o.qty      = s_axis_tdata[14:7];
    q_cmd_o.coin_add = '0;

    unique case (coin)
      vcc_pkg::COIN_NICKEL:  q_cmd_o.coin_add = vcc_pkg::VAL_NICKEL;
      vcc_pkg::COIN_DIME:    q_cmd_o.coin_add = vcc_pkg::VAL_DIME;
      vcc_pkg::COIN_QUARTER: q_cmd_o.coin_add = vcc_pkg::VAL_QUARTER;
      default:               q_cmd_o.coin_add = '0;
    endcase

    unique case (action)
      vcc_pkg::ACT_TICK:    q_cmd_o.op = vcc_pkg::OP_TICK;
      vcc_pkg::ACT_SELECT:  q_cmd_o.op = vcc_pkg::OP_SELECT;
      // drop unknown coins here, they leave all state alone
      vcc_pkg::ACT_COIN:    q_cmd_o.op = (coin == vcc_pkg::COIN_NICKEL ||
                                          coin == vcc_pkg::COIN_DIME ||
                                          coin == vcc_pkg::COIN_QUARTER)
                                         ? vcc_pkg::OP_COIN : vcc_pkg::OP_NONE;
      vcc_pkg::ACT_CONFIRM: q_cmd_o.op = vcc_pkg::OP_CONFIRM;
      vcc_pkg::ACT_RESTOCK: q_cmd_o.op = vcc_pkg::OP_RESTOCK;
      default:              q_cmd_o.op = vcc_pkg::OP_NONE;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/vcc_queue.sv =====
// ----------------------------------------------------------------------------
// vcc_queue
// Short command queue between the front and back ends so each side can
// stall on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module vcc_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  vcc_pkg::cmd_t      cmd_i,
  input  wire logic          pop_i,
  output vcc_pkg::cmd_t      head_o,
  output logic               valid_o,
  output logic               ready_o,
  output vcc_pkg::q_status_t status_o
);

  localparam int PTR_W = $clog2(vcc_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(vcc_pkg::QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(vcc_pkg::QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(vcc_pkg::QUEUE_DEPTH - 1);

  vcc_pkg::cmd_t    mem_q [vcc_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q,  count_d;
  logic             do_push, do_pop;

  assign valid_o  = (count_q != '0);
  assign ready_o  = (count_q != FULL_CNT);
  assign do_push  = push_i && ready_o;
  assign do_pop   = pop_i && valid_o;
  assign head_o   = mem_q[rd_ptr_q];
  assign status_o = '{full: !ready_o, empty: !valid_o};

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/vcc_back.sv =====
// ----------------------------------------------------------------------------
// vcc_back
// Execution side: holds prices, stock and the coin session; applies one
// command per cycle while results are taken, and registers each result word.
// ----------------------------------------------------------------------------
`default_nettype none

module vcc_back #(
  parameter int NUM_PRODUCTS = 3
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  vcc_pkg::cfg_wr_t                     cfg_i,
  input  wire logic                            q_valid_i,
  input  vcc_pkg::cmd_t                        q_cmd_i,
  output logic                                 q_pop_o,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output logic [vcc_pkg::OUT_TDATA_W-1:0]      m_axis_tdata
);

  localparam int MW = vcc_pkg::MONEY_W;
  localparam int TW = vcc_pkg::TICKS_W;
  localparam int SW = vcc_pkg::STOCK_W;
  localparam int PW = vcc_pkg::PRICE_W;
  localparam int NW = vcc_pkg::PRODUCT_W;
  localparam int PAD_W = vcc_pkg::OUT_TDATA_W
                       - (vcc_pkg::STATUS_W + 2 * MW + SW + 1);

  logic [PW-1:0] price_q [NUM_PRODUCTS];
  logic [SW-1:0] stock_q [NUM_PRODUCTS];
  logic [SW-1:0] stock_d [NUM_PRODUCTS];
  logic [TW-1:0] timeout_q;
  logic          session_q, session_d;
  logic [NW-1:0] sp_q, sp_d;
  logic [MW-1:0] deposit_q, deposit_d;
  logic [TW-1:0] idle_q, idle_d;
  logic          out_valid_q;
  logic [vcc_pkg::OUT_TDATA_W-1:0] out_data_q, out_data_d;

  logic [PW-1:0]   addr_price, sp_price;
  logic [SW-1:0]   addr_stock, stock_now;
  logic            addr_ok;
  logic [NW-1:0]   shown;
  logic [TW-1:0]   idle_inc;
  logic [MW:0]     coin_sum;
  logic            vend, restock_ok;
  vcc_pkg::status_e status;
  logic [MW-1:0]   change;

  assign q_pop_o       = q_valid_i && (!out_valid_q || m_axis_tready);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // pick the addressed and session product entries
  always_comb begin
    addr_price = '0;
    addr_stock = '0;
    addr_ok    = 1'b0;
    sp_price   = '0;
    for (int k = 0; k < NUM_PRODUCTS; k++) begin
      if (NW'(k) == q_cmd_i.product) begin
        addr_price = price_q[k];
        addr_stock = stock_q[k];
        addr_ok    = 1'b1;
      end
      if (NW'(k) == sp_q) begin
        sp_price = price_q[k];
      end
    end
  end

  always_comb begin
    session_d  = session_q;
    sp_d       = sp_q;
    deposit_d  = deposit_q;
    idle_d     = idle_q;
    status     = vcc_pkg::ST_NONE;
    change     = '0;
    vend       = 1'b0;
    restock_ok = 1'b0;
    shown      = sp_q;
    idle_inc   = (idle_q != vcc_pkg::TICKS_MAX) ? idle_q + TW'(1) : idle_q;
    coin_sum   = {1'b0, deposit_q} + (MW + 1)'(q_cmd_i.coin_add);

    unique case (q_cmd_i.op)
      vcc_pkg::OP_TICK: begin
        if (session_q) begin
          idle_d = idle_inc;
          if (idle_inc >= timeout_q) begin
            change    = deposit_q;
            deposit_d = '0;
            session_d = 1'b0;
            idle_d    = '0;
            status    = vcc_pkg::ST_TIMEOUT;
          end
        end
      end
      vcc_pkg::OP_SELECT: begin
        shown = q_cmd_i.product;
        if (!session_q) begin
          if (addr_ok && addr_price != '0 && addr_stock != '0) begin
            session_d = 1'b1;
            sp_d      = q_cmd_i.product;
            idle_d    = '0;
            status    = vcc_pkg::ST_OPENED;
          end else begin
            status = vcc_pkg::ST_OUT_OF_STOCK;
          end
        end
      end
      vcc_pkg::OP_COIN: begin
        if (session_q) begin
          deposit_d = coin_sum[MW] ? vcc_pkg::DEPOSIT_MAX : coin_sum[MW-1:0];
          idle_d    = '0;
          status    = vcc_pkg::ST_COIN_TAKEN;
        end
      end
      vcc_pkg::OP_CONFIRM: begin
        if (session_q) begin
          if (deposit_q >= MW'(sp_price)) begin
            change = deposit_q - MW'(sp_price);
            vend   = 1'b1;
            status = vcc_pkg::ST_VENDED;
          end else begin
            change = deposit_q;
            status = vcc_pkg::ST_REFUNDED;
          end
          deposit_d = '0;
          session_d = 1'b0;
          idle_d    = '0;
        end
      end
      vcc_pkg::OP_RESTOCK: begin
        shown = q_cmd_i.product;
        if (!session_q && addr_ok && addr_price != '0) begin
          restock_ok = 1'b1;
          status     = vcc_pkg::ST_RESTOCKED;
        end else begin
          status = vcc_pkg::ST_RESTOCK_ERROR;
        end
      end
      default: begin
        status = vcc_pkg::ST_NONE;
      end
    endcase
  end

  // stock update and the stock shown after the update
  always_comb begin
    stock_now = '0;
    for (int k = 0; k < NUM_PRODUCTS; k++) begin
      stock_d[k] = stock_q[k];
      if (restock_ok && NW'(k) == q_cmd_i.product) begin
        stock_d[k] = q_cmd_i.qty;
      end
      if (vend && NW'(k) == sp_q && stock_q[k] != '0) begin
        stock_d[k] = stock_q[k] - SW'(1);
      end
      if (NW'(k) == shown) begin
        stock_now = stock_d[k];
      end
    end
    out_data_d = {PAD_W'(0), session_d, stock_now, deposit_d, change, status};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_PRODUCTS; k++) begin
        price_q[k] <= '0;
        stock_q[k] <= '0;
      end
      timeout_q   <= vcc_pkg::TIMEOUT_RESET;
      session_q   <= 1'b0;
      sp_q        <= '0;
      deposit_q   <= '0;
      idle_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_i.we) begin
        for (int k = 0; k < NUM_PRODUCTS; k++) begin
          if (cfg_i.idx == vcc_pkg::CFG_PRICE_FIRST && k == 0 ||
              cfg_i.idx == vcc_pkg::CFG_PRICE_SECOND && k == 1 ||
              cfg_i.idx == vcc_pkg::CFG_PRICE_THIRD && k == 2) begin
            price_q[k] <= cfg_i.data[PW-1:0];
          end
        end
        if (cfg_i.idx == vcc_pkg::CFG_TIMEOUT) begin
          timeout_q <= cfg_i.data[TW-1:0];
        end
      end
      if (q_pop_o) begin
        for (int k = 0; k < NUM_PRODUCTS; k++) begin
          stock_q[k] <= stock_d[k];
        end
        session_q <= session_d;
        sp_q      <= sp_d;
        deposit_q <= deposit_d;
        idle_q    <= idle_d;
      end
      if (q_pop_o) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      out_data_q <= out_data_d;
    end
  end

endmodule

`default_nettype wire

// ===== bench/tb_vending_coin_controller.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_vending_coin_controller
// Self-checking bench for the vending coin controller. A shadow model of
// prices, stock and the coin session predicts one result word per accepted
// input word. Directed tasks cover idle handling, vend, refund, timeout and
// saturation. Random coin sessions mixed with noise words follow, under
// sender bursts and receiver stalls.
// ----------------------------------------------------------------------------
module tb_vending_coin_controller;
  import vcc_pkg::*;

  localparam int NUM_PROD = 3;
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 90;
  localparam int DRAIN_CYCLES = 4;
  localparam logic [PRODUCT_W-1:0] PROD_BAD = 2'd3;
  localparam logic [COIN_W-1:0] COIN_BAD = 2'd3;

  typedef struct {
    status_e            status;
    logic [MONEY_W-1:0] change;
    logic [MONEY_W-1:0] deposit;
    logic [STOCK_W-1:0] stock;
    logic               session;
  } vend_result_t;

  typedef enum {RX_STEADY, RX_RANDOM, RX_PERIODIC} rx_mode_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_TDATA_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;

  // shadow copy of the machine
  logic [PRICE_W-1:0] mach_price [NUM_PROD];
  logic [TICKS_W-1:0] mach_timeout;
  logic               mach_in_session;
  logic [PRODUCT_W-1:0] mach_sel;
  logic [MONEY_W-1:0] mach_deposit;
  logic [STOCK_W-1:0] mach_stock [NUM_PROD];
  logic [TICKS_W-1:0] mach_idle;

  vend_result_t vend_expect_q[$];
  int errors = 0;
  int words_sent = 0;
  int results_seen = 0;
  int status_hits[16];
  int stall_cycles = 0;
  int burst_left = 0;
  bit gaps_on = 1'b0;
  rx_mode_e rx_mode = RX_STEADY;
  int hold_reqs = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int rx_phase = 0;

  always #1 clk_i = ~clk_i;

  vending_coin_controller #(.NUM_PRODUCTS(NUM_PROD)) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    // action[2:0], product[4:3], coin_kind[6:5], quantity[14:7], zero[15]
    .s_axis_tdata  (s_tdata),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    // status[3:0], change_due[13:4], deposit_now[23:14], stock_now[31:24],
    // session_open[32], zero[39:33]
    .m_axis_tdata  (m_tdata)
  );

  function automatic vend_result_t predict_vend(input logic [ACTION_W-1:0] act,
                                                input logic [PRODUCT_W-1:0] prod,
                                                input logic [COIN_W-1:0] coin,
                                                input logic [QTY_W-1:0] qty);
    vend_result_t r;
    logic [PRODUCT_W-1:0] shown;
    int unsigned add;
    int unsigned price;
    r.status = ST_NONE;
    r.change = '0;
    shown = mach_sel;
    case (act)
      ACT_TICK: begin
        if (mach_in_session) begin
          if (mach_idle != TICKS_MAX) mach_idle++;
          if (mach_idle >= mach_timeout) begin
            r.change = mach_deposit;
            mach_deposit = '0;
            mach_in_session = 1'b0;
            mach_idle = '0;
            r.status = ST_TIMEOUT;
          end
        end
      end
      ACT_SELECT: begin
        shown = prod;
        if (!mach_in_session) begin
          if (prod < NUM_PROD && mach_price[prod] != 0 && mach_stock[prod] != 0) begin
            mach_in_session = 1'b1;
            mach_sel = prod;
            mach_idle = '0;
            r.status = ST_OPENED;
          end else begin
            r.status = ST_OUT_OF_STOCK;
          end
        end
      end
      ACT_COIN: begin
        if (mach_in_session && coin != COIN_BAD) begin
          add = (coin == COIN_NICKEL) ? VAL_NICKEL :
                (coin == COIN_DIME) ? VAL_DIME : VAL_QUARTER;
          if (int'(mach_deposit) + add > int'(DEPOSIT_MAX)) mach_deposit = DEPOSIT_MAX;
          else mach_deposit = MONEY_W'(int'(mach_deposit) + add);
          mach_idle = '0;
          r.status = ST_COIN_TAKEN;
        end
      end
      ACT_CONFIRM: begin
        if (mach_in_session) begin
          price = mach_price[mach_sel];
          if (mach_deposit >= price) begin
            r.change = MONEY_W'(int'(mach_deposit) - price);
            if (mach_stock[mach_sel] != 0) mach_stock[mach_sel]--;
            r.status = ST_VENDED;
          end else begin
            r.change = mach_deposit;
            r.status = ST_REFUNDED;
          end
          mach_deposit = '0;
          mach_in_session = 1'b0;
          mach_idle = '0;
        end
      end
      ACT_RESTOCK: begin
        shown = prod;
        if (!mach_in_session && prod < NUM_PROD && mach_price[prod] != 0) begin
          mach_stock[prod] = qty;
          r.status = ST_RESTOCKED;
        end else begin
          r.status = ST_RESTOCK_ERROR;
        end
      end
      default: ;
    endcase
    r.deposit = mach_deposit;
    r.stock = (shown < NUM_PROD) ? mach_stock[shown] : '0;
    r.session = mach_in_session;
    return r;
  endfunction

  task automatic send_word(input logic [ACTION_W-1:0] act, input logic [PRODUCT_W-1:0] prod,
                           input logic [COIN_W-1:0] coin, input logic [QTY_W-1:0] qty);
    int gap;
    if (gaps_on && burst_left == 0) begin
      gap = $urandom_range(1, 8);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = $urandom_range(1, 16);
    end
    if (burst_left > 0) burst_left--;
    s_tvalid <= 1'b1;
    s_tdata <= {1'b0, qty, coin, prod, act};
    do @(posedge clk_i); while (!s_tready);
    vend_expect_q.push_back(predict_vend(act, prod, coin, qty));
    words_sent++;
  endtask

  // hold the sender until every pending result has been taken
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (vend_expect_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] val);
    drain_results();
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
    if (idx == CFG_TIMEOUT) mach_timeout = val;
    else mach_price[idx] = val[PRICE_W-1:0];
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [QTY_W-1:0] rnd_qty();
    return QTY_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [PRODUCT_W-1:0] rnd_prod();
    return PRODUCT_W'($urandom_range(0, 3));
  endfunction

  task automatic send_tick();
    send_word(ACT_TICK, rnd_prod(), COIN_W'($urandom_range(0, 3)), rnd_qty());
  endtask

  task automatic send_coin(input logic [COIN_W-1:0] coin);
    send_word(ACT_COIN, rnd_prod(), coin, rnd_qty());
  endtask

  task automatic send_confirm();
    send_word(ACT_CONFIRM, rnd_prod(), COIN_W'($urandom_range(0, 3)), rnd_qty());
  endtask

  task automatic send_noise();
    send_word(ACTION_W'($urandom_range(0, 7)), rnd_prod(), COIN_W'($urandom_range(0, 3)),
              rnd_qty());
  endtask

  task automatic check_field(input string what, input int unsigned want, input int unsigned got);
    if (want != got) begin
      errors++;
      if (errors <= 40)
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    vend_result_t want;
    if (m_tvalid && m_tready) begin
      results_seen++;
      status_hits[m_tdata[3:0]]++;
      if (vend_expect_q.size() == 0) begin
        errors++;
        $display("%0t ns: result word with nothing pending, expected none, actual %h",
                 $time, m_tdata);
      end else begin
        want = vend_expect_q.pop_front();
        check_field("status", want.status, m_tdata[3:0]);
        check_field("change_due", want.change, m_tdata[13:4]);
        check_field("deposit_now", want.deposit, m_tdata[23:14]);
        check_field("stock_now", want.stock, m_tdata[31:24]);
        check_field("session_open", want.session, m_tdata[32]);
      end
    end
  end

  // receiver: steady, random or periodic stalls, plus a long hold on request
  always @(posedge clk_i) begin
    rx_phase = (rx_phase + 1) % 7;
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (hold_seen != hold_reqs) begin
      hold_seen = hold_reqs;
      hold_left = HOLD_CYCLES;
      m_tready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_RANDOM:   m_tready <= ($urandom_range(0, 99) >= 35);
        RX_PERIODIC: m_tready <= (rx_phase >= 2);
        default:     m_tready <= 1'b1;
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("no word moved for %0d cycles", STALL_LIMIT);
        $display("FAIL vending_coin_controller");
        $finish;
      end
    end
  end

  // everything unpriced and empty: only refusals and ignored words
  task automatic test_idle_machine();
    send_word(ACT_SELECT, 2'd0, COIN_NICKEL, rnd_qty());
    send_word(ACT_SELECT, PROD_BAD, COIN_DIME, rnd_qty());
    send_coin(COIN_QUARTER);
    send_confirm();
    send_tick();
    send_word(ACT_RESTOCK, 2'd0, COIN_NICKEL, 8'd255);
    for (int a = int'(ACT_RESTOCK) + 1; a < 8; a++)
      send_word(ACTION_W'(a), rnd_prod(), COIN_BAD, rnd_qty());
  endtask

  task automatic test_vend_path();
    write_reg(CFG_PRICE_FIRST, 16'd255);
    write_reg(CFG_PRICE_SECOND, 16'd1);
    write_reg(CFG_PRICE_THIRD, 16'd100);
    send_word(ACT_RESTOCK, PROD_BAD, COIN_NICKEL, 8'd7);
    send_word(ACT_RESTOCK, 2'd0, COIN_NICKEL, 8'd255);
    send_word(ACT_RESTOCK, 2'd1, COIN_NICKEL, 8'd1);
    send_word(ACT_RESTOCK, 2'd2, COIN_NICKEL, 8'd0);
    send_word(ACT_SELECT, 2'd2, COIN_NICKEL, 8'd0);
    send_word(ACT_SELECT, 2'd1, COIN_NICKEL, 8'd0);
    send_word(ACT_SELECT, 2'd0, COIN_NICKEL, 8'd0);
    send_word(ACT_RESTOCK, 2'd0, COIN_NICKEL, 8'd9);
    send_coin(COIN_NICKEL);
    send_coin(COIN_DIME);
    send_coin(COIN_QUARTER);
    send_coin(COIN_BAD);
    send_confirm();
    send_word(ACT_SELECT, 2'd1, COIN_NICKEL, 8'd0);
  endtask

  // short deposit refunds; a price rewrite mid-session applies on confirm
  task automatic test_refund_and_reprice();
    send_word(ACT_SELECT, 2'd0, COIN_DIME, 8'd0);
    send_coin(COIN_DIME);
    send_confirm();
    send_word(ACT_SELECT, 2'd0, COIN_DIME, 8'd0);
    send_coin(COIN_QUARTER);
    write_reg(CFG_PRICE_FIRST, 16'd20);
    send_confirm();
  endtask

  task automatic test_timeouts();
    write_reg(CFG_TIMEOUT, 16'd2);
    send_word(ACT_SELECT, 2'd0, COIN_NICKEL, 8'd0);
    send_coin(COIN_NICKEL);
    send_tick();
    send_coin(COIN_BAD);
    send_tick();
    write_reg(CFG_TIMEOUT, 16'd0);
    send_word(ACT_SELECT, 2'd0, COIN_NICKEL, 8'd0);
    send_tick();
    write_reg(CFG_TIMEOUT, 16'hFFFF);
    send_word(ACT_SELECT, 2'd0, COIN_NICKEL, 8'd0);
    send_tick();
    send_confirm();
  endtask

  task automatic test_deposit_saturation();
    write_reg(CFG_PRICE_FIRST, 16'd255);
    send_word(ACT_SELECT, 2'd0, COIN_NICKEL, 8'd0);
    repeat (45) send_coin(COIN_QUARTER);
    send_coin(COIN_NICKEL);
    send_confirm();
  endtask

  // one well-formed purchase attempt with random content and some noise
  task automatic run_session();
    logic [PRODUCT_W-1:0] prod;
    int n_coins;
    int k;
    prod = ($urandom_range(0, 19) == 0) ? PROD_BAD : PRODUCT_W'($urandom_range(0, 2));
    if (!mach_in_session && prod != PROD_BAD &&
        (mach_stock[prod] == 0 || $urandom_range(0, 3) == 0))
      send_word(ACT_RESTOCK, prod, COIN_W'($urandom_range(0, 3)),
                ($urandom_range(0, 9) == 0) ? 8'd0 : rnd_qty());
    send_word(ACT_SELECT, prod, COIN_W'($urandom_range(0, 3)), rnd_qty());
    n_coins = $urandom_range(0, 10);
    for (int i = 0; i < n_coins; i++) begin
      k = $urandom_range(0, 9);
      if (k == 0) send_noise();
      else if (k <= 2) send_tick();
      else send_coin(($urandom_range(0, 14) == 0) ? COIN_BAD :
                     COIN_W'($urandom_range(COIN_NICKEL, COIN_QUARTER)));
    end
    if (mach_timeout <= 12 && $urandom_range(0, 3) == 0) begin
      k = 0;
      while (mach_in_session && k < 16) begin
        send_tick();
        k++;
      end
    end else begin
      send_confirm();
    end
  endtask

  task automatic reprogram_random();
    int r;
    for (int p = 0; p < NUM_PROD; p++) begin
      r = $urandom_range(0, 9);
      write_reg(cfg_idx_e'(p), {8'($urandom_range(0, 255)),
                r == 0 ? 8'd0 : r == 1 ? 8'd255 :
                r <= 4 ? 8'($urandom_range(1, 30)) : 8'($urandom_range(31, 254))});
    end
    r = $urandom_range(0, 9);
    write_reg(CFG_TIMEOUT, r == 0 ? 16'd1 : r == 1 ? 16'hFFFF :
              r <= 7 ? 16'($urandom_range(2, 8)) : 16'($urandom_range(9, 40)));
    rx_mode = rx_mode_e'($urandom_range(0, 2));
    gaps_on = ($urandom_range(0, 3) != 0);
  endtask

  // stop the receiver while the sender keeps offering, so the input stalls
  task automatic test_backpressure();
    int start;
    drain_results();
    gaps_on = 1'b0;
    rx_mode = RX_STEADY;
    hold_reqs++;
    start = words_sent;
    while (words_sent < start + 24) run_session();
    drain_results();
  endtask

  task automatic test_random_traffic();
    int next_cfg;
    next_cfg = words_sent;
    while (words_sent < 550) begin
      if (words_sent >= next_cfg) begin
        reprogram_random();
        next_cfg = words_sent + $urandom_range(40, 80);
      end
      run_session();
    end
  endtask

  initial begin
    mach_price = '{default: '0};
    mach_stock = '{default: '0};
    mach_timeout = TIMEOUT_RESET;
    mach_in_session = 1'b0;
    mach_sel = '0;
    mach_deposit = '0;
    mach_idle = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_idle_machine();
    test_vend_path();
    test_refund_and_reprice();
    test_timeouts();
    test_deposit_saturation();
    test_backpressure();
    gaps_on = 1'b1;
    rx_mode = RX_RANDOM;
    test_random_traffic();
    drain_results();
    repeat (8) @(posedge clk_i);
    $display("covered %0d input words, %0d results checked", words_sent, results_seen);
    $display("opened %0d, vended %0d, refunded %0d, timed out %0d, restocked %0d",
             status_hits[ST_OPENED], status_hits[ST_VENDED], status_hits[ST_REFUNDED],
             status_hits[ST_TIMEOUT], status_hits[ST_RESTOCKED]);
    if (errors == 0) begin
      $display("PASS vending_coin_controller");
    end else begin
      $display("FAIL vending_coin_controller");
    end
    $finish;
  end

endmodule
